>>> rtl/ric_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the rail interface command encoder.
package ric_pkg;

  localparam int LOCO_SLOTS_DEFAULT = 256;
  localparam int REC_W = 6;
  localparam int MAX_RESULTS = 6;

  // Item modes
  localparam logic [2:0] MODE_POWER = 3'd0;
  localparam logic [2:0] MODE_LOCO  = 3'd1;
  localparam logic [2:0] MODE_ACC   = 3'd2;
  localparam logic [2:0] MODE_POLL  = 3'd3;
  localparam logic [2:0] MODE_REPLY = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_OLD_CENTRAL = 2'd0;
  localparam logic [1:0] REG_FB_MODULES  = 2'd1;
  localparam logic [1:0] REG_ACC_MAX_ON  = 2'd2;

  // Interface byte codes
  localparam logic [7:0] BYTE_POWER_ON   = 8'd96;
  localparam logic [7:0] BYTE_POWER_OFF  = 8'd97;
  localparam logic [3:0] SPEED_REVERSE   = 4'd15;
  localparam logic [3:0] SPEED_MAX       = 4'd14;
  localparam logic [3:0] FUNC_BASE_HI    = 4'b0100;  // 64 + f1..f4
  localparam logic [7:0] BYTE_ACC_RED    = 8'd33;
  localparam logic [7:0] BYTE_ACC_GREEN  = 8'd34;
  localparam logic [7:0] BYTE_ACC_OFF    = 8'd32;
  localparam logic [7:0] BYTE_POLL_BASE  = 8'd192;
  localparam logic [15:0] ACC_MAX_ON_RESET = 16'd75;

endpackage

>>> rtl/ric_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module ric_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rail_interface_command_encoder.sv
`timescale 1ns / 1ps
// Rail interface command encoder: requests to serial interface byte sequences.
//
// An item (power, locomotive, accessory, poll or feedback reply) is taken at a
// clock edge where start is high and busy is low. Its results follow one per
// cycle, each marked by result_valid for exactly one cycle; the receiver takes
// every result and cannot stall the block. The final result of an item carries
// last. Refused items (power off, switch-off pending, polling disabled) give a
// single result with refused set and tx_valid low.
//
// Sequence: the accepting edge reads the locomotive record memory, the
// evaluation state builds the byte plan and writes the record back, then
// the emit state gives one result per cycle. An item has 1 to 6 results and
// keeps busy high through the evaluation and emit states, so the next item
// can be taken only after the last result of the current one. The registered
// memory read and the single result port set this.
//
// Configuration writes (cfg_wr, cfg_index, cfg_data) take effect at once and
// are expected only while busy is low.
// Reset clears track power, the pending switch-off and all locomotive records
// (through per-slot valid bits) and sets the poll rotation to module 1.
module rail_interface_command_encoder
  import ric_pkg::*;
#(
  parameter int LOCO_SLOTS = LOCO_SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic [7:0]         address,
  input  logic               power_on,
  input  logic [3:0]         speed,
  input  logic [1:0]         direction,
  input  logic [4:0]         func_bits,
  input  logic               port,
  input  logic               action,
  input  logic signed [16:0] active_ms,
  input  logic [15:0]        reply_word,
  // results
  output logic               result_valid,
  output logic               tx_valid,
  output logic [7:0]         tx_byte,
  output logic               gap_kind,
  output logic [15:0]        hold_ms,
  output logic               expect_reply,
  output logic               refused,
  output logic               fb_valid,
  output logic [4:0]         fb_module,
  output logic [15:0]        fb_bits,
  output logic               last
);

  localparam int IDX_W = $clog2(LOCO_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;

  // configuration
  logic        old_central_mode;
  logic [4:0]  feedback_modules;
  logic [15:0] accessory_max_on_ms;

  // block state
  logic                  track_power;
  logic                  switch_off_pending;
  logic [4:0]            poll_module;
  logic [LOCO_SLOTS-1:0] loco_valid;

  // latched item
  logic [2:0]       mode_q;
  logic [7:0]       addr_q;
  logic             power_q;
  logic [3:0]       speed_q;
  logic [1:0]       dir_q;
  logic [4:0]       func_q;
  logic             port_q;
  logic             action_q;
  logic [16:0]      active_q;
  logic [15:0]      reply_q;
  logic             stored_q;
  logic [IDX_W-1:0] idx_q;

  // result plan
  logic [7:0]  res_byte [MAX_RESULTS];
  logic [5:0]  res_gap;
  logic [2:0]  res_cnt;
  logic        res_empty;
  logic        res_refused;
  logic        res_fb;
  logic [4:0]  res_module;
  logic [15:0] res_hold;
  logic        res_hold_at1;
  logic        res_expect;
  logic [2:0]  k;

  // memory
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  logic             rec_we;
  logic [REC_W-1:0] rec_wdata;

  // plan built in the evaluation cycle
  logic [7:0]  p_byte [MAX_RESULTS];
  logic [5:0]  p_gap;
  logic [2:0]  p_cnt;
  logic        p_empty;
  logic        p_refused;
  logic        p_fb;
  logic [4:0]  p_module;
  logic [15:0] p_hold;
  logic        p_hold_at1;
  logic        p_expect;
  logic        power_next;
  logic        pending_next;
  logic [4:0]  poll_next;

  logic        accept;
  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign ram_raddr = address[IDX_W-1:0];

  ric_ram #(
    .WIDTH (REC_W),
    .DEPTH (LOCO_SLOTS)
  ) u_loco_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (idx_q),
    .wdata (rec_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic [REC_W-1:0] rec;
    logic             odir;
    logic [4:0]       ofun;
    logic             ndir;
    logic [3:0]       spd;
    logic             rev;
    logic             ext;
    logic [4:0]       fix_mod;
    logic [5:0]       mod_inc;
    logic             neg;
    logic [15:0]      act;
    logic [7:0]       b_rev;
    logic [7:0]       b_spd;
    logic [7:0]       b_ext;

    for (int i = 0; i < MAX_RESULTS; i++) begin
      p_byte[i] = '0;
    end
    p_gap        = '0;
    p_cnt        = 3'd1;
    p_empty      = 1'b0;
    p_refused    = 1'b0;
    p_fb         = 1'b0;
    p_module     = '0;
    p_hold       = '0;
    p_hold_at1   = 1'b0;
    p_expect     = 1'b0;
    power_next   = track_power;
    pending_next = switch_off_pending;
    poll_next    = poll_module;
    rec_we       = 1'b0;

    rec  = (stored_q && loco_valid[idx_q]) ? ram_rdata : '0;
    odir = rec[5];
    ofun = rec[4:0];
    spd  = (speed_q > SPEED_MAX) ? SPEED_MAX : speed_q;
    if (dir_q[1]) begin
      spd  = '0;
      ndir = ~odir;
    end else begin
      ndir = dir_q[0];
    end
    rev   = (ndir != odir);
    ext   = !old_central_mode && (func_q != ofun);
    b_rev = {3'b000, func_q[0], SPEED_REVERSE};
    b_spd = {3'b000, func_q[0], spd};
    b_ext = {FUNC_BASE_HI, func_q[4:1]};
    rec_wdata = {ndir, func_q};

    fix_mod = (poll_module == 5'd0 || poll_module > feedback_modules) ? 5'd1 : poll_module;
    mod_inc = {1'b0, fix_mod} + 6'd1;
    neg     = active_q[16];
    act     = active_q[15:0];

    unique case (mode_q)
      MODE_POWER: begin
        p_byte[0]  = power_q ? BYTE_POWER_ON : BYTE_POWER_OFF;
        p_byte[1]  = p_byte[0];
        p_gap      = 6'b000011;
        p_cnt      = 3'd2;
        power_next = power_q;
      end
      MODE_LOCO: begin
        if (!track_power || switch_off_pending) begin
          p_empty   = 1'b1;
          p_refused = 1'b1;
        end else begin
          // write back only in the evaluation cycle, while the read data is valid
          rec_we = stored_q && (state == ST_EVAL);
          if (rev) begin
            p_byte[0] = b_rev;
            p_byte[1] = addr_q;
            p_byte[2] = b_spd;
            p_byte[3] = addr_q;
            p_byte[4] = b_ext;
            p_byte[5] = addr_q;
            p_gap     = 6'b101010;
            p_cnt     = ext ? 3'd6 : 3'd4;
          end else begin
            p_byte[0] = b_spd;
            p_byte[1] = addr_q;
            p_byte[2] = b_ext;
            p_byte[3] = addr_q;
            p_gap     = 6'b001010;
            p_cnt     = ext ? 3'd4 : 3'd2;
          end
        end
      end
      MODE_ACC: begin
        if (!track_power) begin
          p_empty   = 1'b1;
          p_refused = 1'b1;
        end else if (action_q) begin
          p_byte[0]  = port_q ? BYTE_ACC_RED : BYTE_ACC_GREEN;
          p_byte[1]  = addr_q;
          p_byte[2]  = BYTE_ACC_OFF;
          p_gap      = 6'b000100;
          p_hold     = (neg || act > accessory_max_on_ms) ? accessory_max_on_ms : act;
          p_hold_at1 = 1'b1;
          // unlimited on time: leave the switch-off pending
          p_cnt        = neg ? 3'd2 : 3'd3;
          pending_next = neg;
        end else if (switch_off_pending) begin
          p_byte[0]    = BYTE_ACC_OFF;
          p_gap        = 6'b000001;
          pending_next = 1'b0;
        end else begin
          p_empty = 1'b1;
        end
      end
      MODE_POLL: begin
        if (!track_power || switch_off_pending || feedback_modules == 5'd0) begin
          p_empty   = 1'b1;
          p_refused = 1'b1;
        end else begin
          p_byte[0] = BYTE_POLL_BASE + {3'b000, fix_mod};
          p_gap     = 6'b000001;
          p_expect  = 1'b1;
          poll_next = fix_mod;
        end
      end
      MODE_REPLY: begin
        if (feedback_modules == 5'd0) begin
          p_empty   = 1'b1;
          p_refused = 1'b1;
        end else begin
          p_fb      = 1'b1;
          p_module  = fix_mod;
          poll_next = (mod_inc > {1'b0, feedback_modules}) ? 5'd1 : mod_inc[4:0];
        end
      end
      default: begin
        p_empty = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      old_central_mode    <= 1'b0;
      feedback_modules    <= '0;
      accessory_max_on_ms <= ACC_MAX_ON_RESET;
      track_power         <= 1'b0;
      switch_off_pending  <= 1'b0;
      poll_module         <= 5'd1;
      loco_valid          <= '0;
      k                   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_OLD_CENTRAL: old_central_mode    <= cfg_data[0];
          REG_FB_MODULES:  feedback_modules    <= cfg_data[4:0];
          REG_ACC_MAX_ON:  accessory_max_on_ms <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          track_power        <= power_next;
          switch_off_pending <= pending_next;
          poll_module        <= poll_next;
          if (rec_we) begin
            loco_valid[idx_q] <= 1'b1;
          end
          k     <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // advance one result per cycle, drop back to idle after the last
          if (last) begin
            state <= ST_IDLE;
          end else begin
            k <= k + 3'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item and plan registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      addr_q   <= address;
      power_q  <= power_on;
      speed_q  <= speed;
      dir_q    <= direction;
      func_q   <= func_bits;
      port_q   <= port;
      action_q <= action;
      active_q <= active_ms;
      reply_q  <= reply_word;
      stored_q <= ({1'b0, address} < 9'(LOCO_SLOTS));
      idx_q    <= address[IDX_W-1:0];
    end
    if (state == ST_EVAL) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_byte[i] <= p_byte[i];
      end
      res_gap      <= p_gap;
      res_cnt      <= p_cnt;
      res_empty    <= p_empty;
      res_refused  <= p_refused;
      res_fb       <= p_fb;
      res_module   <= p_module;
      res_hold     <= p_hold;
      res_hold_at1 <= p_hold_at1;
      res_expect   <= p_expect;
    end
  end

  logic plain;
  assign plain = !res_empty && !res_fb;

  assign result_valid = (state == ST_EMIT);
  assign last         = (k == res_cnt - 3'd1);
  assign tx_valid     = plain;
  assign tx_byte      = plain ? res_byte[k] : 8'd0;
  assign gap_kind     = plain && res_gap[k];
  assign hold_ms      = (plain && res_hold_at1 && k == 3'd1) ? res_hold : 16'd0;
  assign expect_reply = plain && res_expect && (k == 3'd0);
  assign refused      = res_empty && res_refused;
  assign fb_valid     = res_fb;
  assign fb_module    = res_fb ? res_module : 5'd0;
  assign fb_bits      = res_fb ? reply_q : 16'd0;

  // results of one item come back to back
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("result stream broken before last");

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result after last of item");

  a_refused_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && refused |-> last && !tx_valid && !fb_valid)
    else $error("refused item produced traffic");

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result while block idle");

endmodule
